FILE: src/flt_pkg.sv
// ----------------------------------------------------------------------------
// flt_pkg
// Shared types and constants for the ticket queue and stack block: command and
// status codes, field widths and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package flt_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CMD_W    = 3;
  localparam int TICKET_W = 32;
  localparam int STATUS_W = 2;
  localparam int MOVED_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRANSFER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNK_A    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNK_B    = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                enq;
    logic                deq;
    logic                push;
    logic                pop;
    logic                clr;
    logic                xfer;
    logic                mov_clr;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_q;
    logic                res_s;
    logic                res_mov;
  } flt_ctl_t;

  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic s_empty;
    logic s_full;
  } flt_stat_t;

endpackage

`default_nettype wire

FILE: src/fifo_and_lifo_with_transfer.sv
// ----------------------------------------------------------------------------
// fifo_and_lifo_with_transfer
// Bounded ticket queue and ticket stack, DEPTH entries each, with a transfer
// command that moves queue entries from the front onto the stack.
//
// Command channel: an item (in_command, in_ticket) is taken on a clock edge
// with start high and busy low. Every item gives one result on out_status,
// out_served and out_moved, shown for one cycle with out_valid high; the
// receiver cannot stall it.
// Results and busy per command:
//   enqueue, push, clear, unknown command, and a dequeue or pop that finds
//   its store empty: result in the cycle after the item, busy stays low, one
//   item per cycle.
//   dequeue and pop: the memory read is registered first, and the result is
//   loaded from it in the S_DEQ or S_POP state, with busy high in that state.
//   transfer of n entries: one entry per cycle through the queue read port
//   and stack write port; busy stays high until the result is loaded.
// Reset (rst_n low, synchronous): both stores become empty, no result is
// pending and busy drops; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_and_lifo_with_transfer #(
  parameter int DEPTH = flt_pkg::DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [flt_pkg::CMD_W-1:0]             in_command,
  input  wire logic signed [flt_pkg::TICKET_W-1:0]   in_ticket,
  output logic                                       out_valid,
  output logic [flt_pkg::STATUS_W-1:0]               out_status,
  output logic signed [flt_pkg::TICKET_W-1:0]        out_served,
  output logic [flt_pkg::MOVED_W-1:0]                out_moved
);

  flt_pkg::flt_ctl_t  ctl;
  flt_pkg::flt_stat_t stat;

  flt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctl        (ctl),
    .busy       (busy)
  );

  flt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_ticket  (in_ticket),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_served (out_served),
    .out_moved  (out_moved)
  );

endmodule

`default_nettype wire

FILE: src/flt_dp.sv
// ----------------------------------------------------------------------------
// flt_dp
// Datapath: queue and stack memories, head and count registers, the transfer
// write pipeline and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module flt_dp #(
  parameter int DEPTH = flt_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire flt_pkg::flt_ctl_t                 ctl,
  input  wire logic signed [flt_pkg::TICKET_W-1:0] in_ticket,
  output flt_pkg::flt_stat_t                     stat,
  output logic                                   out_valid,
  output logic [flt_pkg::STATUS_W-1:0]           out_status,
  output logic signed [flt_pkg::TICKET_W-1:0]    out_served,
  output logic [flt_pkg::MOVED_W-1:0]            out_moved
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(DEPTH + 1);

  logic [flt_pkg::TICKET_W-1:0] qmem [DEPTH];
  logic [flt_pkg::TICKET_W-1:0] smem [DEPTH];

  logic [AW-1:0] q_head_r, q_head_nxt;
  logic [CW-1:0] q_count_r, q_count_nxt;
  logic [CW-1:0] s_count_r, s_count_nxt;
  logic [CW-1:0] moved_r, moved_nxt;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;
  logic [flt_pkg::TICKET_W-1:0] q_rd_r;
  logic [flt_pkg::TICKET_W-1:0] s_rd_r;

  logic                         out_valid_r;
  logic [flt_pkg::STATUS_W-1:0] out_status_r;
  logic [flt_pkg::TICKET_W-1:0] out_served_r, out_served_nxt;
  logic [flt_pkg::MOVED_W-1:0]  out_moved_r, out_moved_nxt;

  logic [AW1-1:0] q_sum;
  logic [AW-1:0]  q_tail;
  logic [AW-1:0]  q_head_inc;
  logic [CW-1:0]  s_dec;
  logic [AW-1:0]  s_top;
  logic           s_wr_en;
  logic [AW-1:0]  s_wr_addr;
  logic [flt_pkg::TICKET_W-1:0] s_wr_data;
  logic [31:0]    moved_ext;

  assign q_sum  = {1'b0, q_head_r} + AW1'(q_count_r);
  assign q_tail = (q_sum >= AW1'(DEPTH)) ? AW'(q_sum - AW1'(DEPTH)) : q_sum[AW-1:0];
  assign q_head_inc = (q_head_r == AW'(DEPTH - 1)) ? '0 : q_head_r + AW'(1);
  assign s_dec  = s_count_r - CW'(1);
  assign s_top  = s_dec[AW-1:0];

  assign stat.q_empty = (q_count_r == '0);
  assign stat.q_full  = (q_count_r == CW'(DEPTH));
  assign stat.s_empty = (s_count_r == '0);
  assign stat.s_full  = (s_count_r == CW'(DEPTH));

  assign s_wr_en   = ctl.push | pend_r;
  assign s_wr_addr = ctl.push ? s_count_r[AW-1:0] : pend_addr_r;
  assign s_wr_data = ctl.push ? in_ticket : q_rd_r;

  assign moved_ext = 32'(moved_r);

  always_comb begin
    q_head_nxt  = q_head_r;
    q_count_nxt = q_count_r;
    s_count_nxt = s_count_r;
    moved_nxt   = moved_r;
    if (ctl.clr) begin
      q_head_nxt  = '0;
      q_count_nxt = '0;
      s_count_nxt = '0;
    end
    if (ctl.enq) begin
      q_count_nxt = q_count_r + CW'(1);
    end
    if (ctl.deq || ctl.xfer) begin
      q_head_nxt  = q_head_inc;
      q_count_nxt = q_count_r - CW'(1);
    end
    if (ctl.push || ctl.xfer) begin
      s_count_nxt = s_count_r + CW'(1);
    end
    if (ctl.pop) begin
      s_count_nxt = s_dec;
    end
    if (ctl.mov_clr) begin
      moved_nxt = '0;
    end else if (ctl.xfer) begin
      moved_nxt = moved_r + CW'(1);
    end
  end

  always_comb begin
    out_served_nxt = '0;
    if (ctl.res_q) begin
      out_served_nxt = q_rd_r;
    end else if (ctl.res_s) begin
      out_served_nxt = s_rd_r;
    end
    out_moved_nxt = ctl.res_mov ? moved_ext[flt_pkg::MOVED_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r    <= '0;
      q_count_r   <= '0;
      s_count_r   <= '0;
      moved_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      q_head_r    <= q_head_nxt;
      q_count_r   <= q_count_nxt;
      s_count_r   <= s_count_nxt;
      moved_r     <= moved_nxt;
      pend_r      <= ctl.xfer;
      out_valid_r <= ctl.res_load;
    end
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      qmem[q_tail] <= in_ticket;
    end
    if (ctl.deq || ctl.xfer) begin
      q_rd_r <= qmem[q_head_r];
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (s_wr_en) begin
      smem[s_wr_addr] <= s_wr_data;
    end
    if (ctl.pop) begin
      s_rd_r <= smem[s_top];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.xfer) begin
      pend_addr_r <= s_count_r[AW-1:0];
    end
    if (ctl.res_load) begin
      out_status_r <= ctl.res_status;
      out_served_r <= out_served_nxt;
      out_moved_r  <= out_moved_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_served = out_served_r;
  assign out_moved  = out_moved_r;

endmodule

`default_nettype wire

FILE: src/flt_ctrl.sv
// ----------------------------------------------------------------------------
// flt_ctrl
// Controller: decodes each accepted command, sequences reads and the
// transfer walk, and issues control to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module flt_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [flt_pkg::CMD_W-1:0]   in_command,
  input  wire flt_pkg::flt_stat_t          stat,
  output flt_pkg::flt_ctl_t                ctl,
  output logic                             busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_POP  = 4'b0100,
    S_XFER = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   go;

  assign go   = !stat.q_empty && !stat.s_full;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            flt_pkg::CMD_ENQUEUE: begin
              ctl.res_load = 1'b1;
              if (stat.q_full) begin
                ctl.res_status = flt_pkg::ST_FULL;
              end else begin
                ctl.enq        = 1'b1;
                ctl.res_status = flt_pkg::ST_OK;
              end
            end
            flt_pkg::CMD_DEQUEUE: begin
              if (stat.q_empty) begin
                ctl.res_load   = 1'b1;
                ctl.res_status = flt_pkg::ST_EMPTY;
              end else begin
                ctl.deq   = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            flt_pkg::CMD_PUSH: begin
              ctl.res_load = 1'b1;
              if (stat.s_full) begin
                ctl.res_status = flt_pkg::ST_FULL;
              end else begin
                ctl.push       = 1'b1;
                ctl.res_status = flt_pkg::ST_OK;
              end
            end
            flt_pkg::CMD_POP: begin
              if (stat.s_empty) begin
                ctl.res_load   = 1'b1;
                ctl.res_status = flt_pkg::ST_EMPTY;
              end else begin
                ctl.pop   = 1'b1;
                state_nxt = S_POP;
              end
            end
            flt_pkg::CMD_TRANSFER: begin
              ctl.mov_clr = 1'b1;
              state_nxt   = S_XFER;
            end
            flt_pkg::CMD_CLEAR: begin
              ctl.clr        = 1'b1;
              ctl.res_load   = 1'b1;
              ctl.res_status = flt_pkg::ST_OK;
            end
            default: begin
              ctl.res_load   = 1'b1;
              ctl.res_status = flt_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      S_DEQ: begin
        ctl.res_load   = 1'b1;
        ctl.res_q      = 1'b1;
        ctl.res_status = flt_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end
      S_POP: begin
        ctl.res_load   = 1'b1;
        ctl.res_s      = 1'b1;
        ctl.res_status = flt_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end
      S_XFER: begin
        if (go) begin
          ctl.xfer = 1'b1;
        end else begin
          ctl.res_load   = 1'b1;
          ctl.res_mov    = 1'b1;
          ctl.res_status = stat.q_empty ? flt_pkg::ST_OK : flt_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/flt_chk.sv
// ----------------------------------------------------------------------------
// flt_chk
// Port-level checker for the ticket queue and stack block, bound to the top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module flt_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic [flt_pkg::CMD_W-1:0]           in_command,
  input wire logic signed [flt_pkg::TICKET_W-1:0] in_ticket,
  input wire logic                                out_valid,
  input wire logic [flt_pkg::STATUS_W-1:0]        out_status,
  input wire logic signed [flt_pkg::TICKET_W-1:0] out_served,
  input wire logic [flt_pkg::MOVED_W-1:0]         out_moved
);

  logic acc;
  assign acc = start && !busy;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy after reset");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_command == flt_pkg::CMD_UNK_A || in_command == flt_pkg::CMD_UNK_B)
    |=> out_valid && out_status == flt_pkg::ST_UNKNOWN && !busy)
    else $error("unknown command not reported");

  a_enq_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_command == flt_pkg::CMD_ENQUEUE || in_command == flt_pkg::CMD_PUSH)
    |=> out_valid && out_moved == '0 && out_served == '0)
    else $error("enqueue or push result missing");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != flt_pkg::ST_OK && out_status != flt_pkg::ST_FULL
    |-> out_served == '0 && out_moved == '0)
    else $error("nonzero payload on failed item");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_command == flt_pkg::CMD_DEQUEUE |=> !out_valid || !busy)
    else $error("dequeue result overlapped busy");

endmodule

bind fifo_and_lifo_with_transfer flt_chk u_flt_chk (.*);

`default_nettype wire

FILE: dv/fifo_and_lifo_with_transfer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_and_lifo_with_transfer_tb
// Self-checking bench for the ticket queue and stack. Commands go in on the
// start/busy channel and every result strobe is compared field by field with
// a cycle-free model of both stores kept in the bench. A short directed part
// covers empty stores, extreme tickets and unknown commands. It is followed
// by random bursts that fill, overflow, drain, transfer and clear the stores
// under three sender idle profiles.
// ----------------------------------------------------------------------------

module fifo_and_lifo_with_transfer_tb;

  localparam int DEPTH = flt_pkg::DEPTH_DEF;

  typedef logic [flt_pkg::CMD_W-1:0] cmd_t;

  typedef struct packed {
    logic [flt_pkg::STATUS_W-1:0]        status;
    logic signed [flt_pkg::TICKET_W-1:0] served;
    logic [flt_pkg::MOVED_W-1:0]         moved;
  } ticket_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [flt_pkg::CMD_W-1:0] in_command = flt_pkg::CMD_ENQUEUE;
  logic signed [flt_pkg::TICKET_W-1:0] in_ticket = '0;
  logic busy;
  logic out_valid;
  logic [flt_pkg::STATUS_W-1:0] out_status;
  logic signed [flt_pkg::TICKET_W-1:0] out_served;
  logic [flt_pkg::MOVED_W-1:0] out_moved;

  logic [flt_pkg::TICKET_W-1:0] queue_mem [DEPTH];
  int queue_head = 0;
  int queue_count = 0;
  logic [flt_pkg::TICKET_W-1:0] stack_mem [DEPTH];
  int stack_count = 0;

  ticket_result_t pending_results [$];
  ticket_result_t oldest_result;
  int error_count = 0;
  int idle_pct = 0;
  int items_sent = 0;

  fifo_and_lifo_with_transfer #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_ticket  (in_ticket),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_served (out_served),
    .out_moved  (out_moved)
  );

  always #4 clk = ~clk;

  function automatic ticket_result_t predict_ticket_result(
    input logic [flt_pkg::CMD_W-1:0] cmd, input logic signed [flt_pkg::TICKET_W-1:0] ticket);
    ticket_result_t r;
    r = '{status: flt_pkg::ST_OK, served: '0, moved: '0};
    case (cmd)
      flt_pkg::CMD_ENQUEUE: begin
        if (queue_count >= DEPTH) begin
          r.status = flt_pkg::ST_FULL;
        end else begin
          queue_mem[(queue_head + queue_count) % DEPTH] = ticket;
          queue_count++;
        end
      end
      flt_pkg::CMD_DEQUEUE: begin
        if (queue_count == 0) begin
          r.status = flt_pkg::ST_EMPTY;
        end else begin
          r.served = queue_mem[queue_head];
          queue_head = (queue_head + 1) % DEPTH;
          queue_count--;
        end
      end
      flt_pkg::CMD_PUSH: begin
        if (stack_count >= DEPTH) begin
          r.status = flt_pkg::ST_FULL;
        end else begin
          stack_mem[stack_count] = ticket;
          stack_count++;
        end
      end
      flt_pkg::CMD_POP: begin
        if (stack_count == 0) begin
          r.status = flt_pkg::ST_EMPTY;
        end else begin
          stack_count--;
          r.served = stack_mem[stack_count];
        end
      end
      flt_pkg::CMD_TRANSFER: begin
        while (queue_count != 0 && stack_count < DEPTH) begin
          stack_mem[stack_count] = queue_mem[queue_head];
          stack_count++;
          queue_head = (queue_head + 1) % DEPTH;
          queue_count--;
          r.moved = r.moved + 1'b1;
        end
        if (queue_count != 0) r.status = flt_pkg::ST_FULL;
      end
      flt_pkg::CMD_CLEAR: begin
        queue_head = 0;
        queue_count = 0;
        stack_count = 0;
      end
      default: begin
        r.status = flt_pkg::ST_UNKNOWN;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [flt_pkg::TICKET_W-1:0] pick_ticket();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // called just after a rising edge; returns at the edge that takes the item
  task automatic send_item(input logic [flt_pkg::CMD_W-1:0] cmd,
                           input logic signed [flt_pkg::TICKET_W-1:0] ticket);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_ticket <= ticket;
    @(negedge clk);
    while (busy) @(negedge clk);
    pending_results.push_back(predict_ticket_result(cmd, ticket));
    items_sent++;
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 32'(out_status), '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status)
          report_mismatch("status", 32'(out_status), 32'(oldest_result.status));
        if (out_served !== oldest_result.served)
          report_mismatch("served", out_served, oldest_result.served);
        if (out_moved !== oldest_result.moved)
          report_mismatch("moved", 32'(out_moved), 32'(oldest_result.moved));
      end
    end
  end

  task automatic test_empty_stores();
    send_item(flt_pkg::CMD_DEQUEUE, pick_ticket());
    send_item(flt_pkg::CMD_POP, pick_ticket());
    send_item(flt_pkg::CMD_TRANSFER, pick_ticket());
  endtask

  task automatic test_extreme_tickets();
    send_item(flt_pkg::CMD_ENQUEUE, 32'h8000_0000);
    send_item(flt_pkg::CMD_ENQUEUE, 32'h7fff_ffff);
    send_item(flt_pkg::CMD_PUSH, 32'hffff_ffff);
    send_item(flt_pkg::CMD_PUSH, 32'h0000_0000);
    send_item(flt_pkg::CMD_DEQUEUE, 32'h1234_5678);
    send_item(flt_pkg::CMD_POP, 32'hffff_ffff);
    send_item(flt_pkg::CMD_ENQUEUE, 32'h5555_5555);
    send_item(flt_pkg::CMD_ENQUEUE, 32'haaaa_aaaa);
    send_item(flt_pkg::CMD_TRANSFER, 32'hffff_ffff);
    repeat (5) send_item(flt_pkg::CMD_POP, pick_ticket());
  endtask

  task automatic test_unknown_and_clear();
    send_item(flt_pkg::CMD_UNK_A, 32'hffff_ffff);
    send_item(flt_pkg::CMD_ENQUEUE, 32'h0bad_cafe);
    send_item(flt_pkg::CMD_PUSH, 32'h0dea_dbee);
    send_item(flt_pkg::CMD_UNK_B, 32'h0000_0000);
    send_item(flt_pkg::CMD_CLEAR, pick_ticket());
    send_item(flt_pkg::CMD_DEQUEUE, pick_ticket());
    send_item(flt_pkg::CMD_POP, pick_ticket());
  endtask

  task automatic test_random_traffic(input int n_items, input int sender_idle);
    int stop_at;
    int len;
    stop_at = items_sent + n_items;
    idle_pct = sender_idle;
    while (items_sent < stop_at) begin
      len = $urandom_range(1, DEPTH + 3);
      case ($urandom_range(9))
        0, 1: repeat (len) send_item(flt_pkg::CMD_ENQUEUE, pick_ticket());
        2: repeat (len) send_item(flt_pkg::CMD_PUSH, pick_ticket());
        3: repeat (len) send_item(flt_pkg::CMD_DEQUEUE, pick_ticket());
        4: repeat (len) send_item(flt_pkg::CMD_POP, pick_ticket());
        5: send_item(flt_pkg::CMD_TRANSFER, pick_ticket());
        6: begin
          if ($urandom_range(2) == 0) send_item(flt_pkg::CMD_CLEAR, pick_ticket());
          else send_item(flt_pkg::CMD_TRANSFER, pick_ticket());
        end
        7, 8: begin
          repeat ($urandom_range(1, 8)) send_item(cmd_t'($urandom_range(0, 5)), pick_ticket());
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_item(cmd_t'($urandom_range(0, 7)), $urandom);
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 23;
    test_empty_stores();
    test_extreme_tickets();
    test_unknown_and_clear();
    test_random_traffic(330, 23);
    test_random_traffic(330, 55);
    test_random_traffic(330, 0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("fifo_and_lifo_with_transfer_tb passed");
    end else begin
      $display("fifo_and_lifo_with_transfer_tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("fifo_and_lifo_with_transfer_tb failed");
    $finish;
  end

endmodule
